// ----- design/bcfc_pkg.sv -----
// Package with shared types and constants for the banked cartridge flash controller.
`timescale 1ns / 1ps
`default_nettype none
package bcfc_pkg;

   localparam int BANK_BYTES   = 8192;
   localparam int FLASH_BYTES  = 524288;
   localparam int SECTOR_BYTES = 65536;

   localparam int OFFSET_W = $clog2(BANK_BYTES);
   localparam int BANK_W   = 6;
   localparam int IDX_W    = BANK_W + OFFSET_W;
   localparam int PTR_W    = IDX_W + 1;
   localparam int FLASH_AW = $clog2(FLASH_BYTES);

   localparam logic [15:0] CTRL_ADDR = 16'hDE00;
   localparam logic [15:0] WIN_BASE  = 16'h8000;

   localparam logic [OFFSET_W-1:0] OFS_555 = OFFSET_W'(16'h0555);
   localparam logic [OFFSET_W-1:0] OFS_2AA = OFFSET_W'(16'h02AA);

   localparam logic [7:0] CMD_UNLOCK1   = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2   = 8'h55;
   localparam logic [7:0] CMD_PROGRAM   = 8'hA0;
   localparam logic [7:0] CMD_ERASE     = 8'h80;
   localparam logic [7:0] CMD_AUTOSEL   = 8'h90;
   localparam logic [7:0] CMD_RESET     = 8'hF0;
   localparam logic [7:0] CMD_CHIP_ERS  = 8'h10;
   localparam logic [7:0] CMD_SECT_ERS  = 8'h30;

   localparam logic [7:0] ID_MAKER  = 8'h01;
   localparam logic [7:0] ID_DEVICE = 8'hA4;
   localparam logic [7:0] ERASED    = 8'hFF;

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      logic        eeprom_data_out;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [5:0] rom_bank;
      logic       exrom_high;
      logic       eeprom_select;
      logic       eeprom_clock;
      logic       eeprom_data_in;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_SWEEP = 4'b0100,
      S_DONE  = 4'b1000
   } seq_state_type;

   typedef enum logic [6:0] {
      U_IDLE    = 7'b0000001,
      U_UNLOCK1 = 7'b0000010,
      U_UNLOCK2 = 7'b0000100,
      U_PROGRAM = 7'b0001000,
      U_ESETUP  = 7'b0010000,
      U_EUNLK1  = 7'b0100000,
      U_EUNLK2  = 7'b1000000
   } unlock_state_type;

endpackage
`default_nettype wire

// ----- design/bcfc_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bcfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  addr,
   input  wire [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- design/banked_cartridge_flash_controller.sv -----
// Top level of the banked cartridge flash controller.
`timescale 1ns / 1ps
`default_nettype none
// The block serves one processor bus beat at a time and returns exactly one result beat
// for each. A control register at 0xDE00 selects a bank of the flash, drives the serial
// EEPROM pins and EXROM, and enables flash commands; the flash window at 0x8000-0x9FFF
// reads the selected bank or autoselect IDs, and enabled writes there run the unlock
// command sequence (reset, program by AND, chip erase, sector erase, autoselect). The
// flash lives in one byte-wide synchronous RAM. An ordinary access passes S_IDLE, S_EXEC
// and S_DONE: the accept cycle presents the RAM address, S_EXEC has the RAM data and does
// the modify and write back, and S_DONE loads the result register once the result
// channel does not stall. A sector erase walks the RAM one byte a cycle over its sector
// of SECTOR_BYTES (65536), a chip erase over all FLASH_BYTES (524288). After reset
// a clearing pass writes every flash byte to 0xFF; req_stall stays high until done.
module banked_cartridge_flash_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire bcfc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output bcfc_pkg::rsp_type      rsp_data
);

   // Sequencer and command state.
   bcfc_pkg::seq_state_type    state_ff, state_in;
   bcfc_pkg::unlock_state_type unlock_ff, unlock_in;
   logic                       auto_ff, auto_in;
   logic [7:0]                 ctrl_ff, ctrl_in;
   logic                       resp_pend_ff, resp_pend_in;

   // Erase and clearing sweep pointer and its end (exclusive).
   logic [bcfc_pkg::PTR_W-1:0] sweep_ptr_ff, sweep_ptr_in;
   logic [bcfc_pkg::PTR_W-1:0] sweep_end_ff, sweep_end_in;

   // Payload registers.
   bcfc_pkg::req_type item_ff, item_in;
   logic [7:0]        rd_ff, rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bcfc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM port.
   logic                          ram_we;
   logic [bcfc_pkg::FLASH_AW-1:0] ram_addr;
   logic [7:0]                    ram_wdata;
   logic [7:0]                    ram_rdata;

   logic                          req_accept;
   logic                          slot_free;
   logic [bcfc_pkg::OFFSET_W-1:0] offset;
   logic [bcfc_pkg::PTR_W-1:0]    idx;
   logic [bcfc_pkg::PTR_W-1:0]    req_idx;
   logic [bcfc_pkg::PTR_W-1:0]    sect_base;
   logic [bcfc_pkg::PTR_W-1:0]    sect_end;
   logic                          idx_ok;
   logic                          in_window;
   logic                          is_ctrl;
   logic                          at555;
   logic                          at2aa;
   logic                          advance;

   bcfc_ram #(
      .WIDTH (8),
      .DEPTH (bcfc_pkg::FLASH_BYTES)
   ) u_flash (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_stall  = (state_ff != bcfc_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Decode of the latched beat.
   assign offset    = item_ff.bus_address[bcfc_pkg::OFFSET_W-1:0];
   assign idx       = {1'b0, ctrl_ff[bcfc_pkg::BANK_W-1:0], offset};
   assign req_idx   = {1'b0, ctrl_ff[bcfc_pkg::BANK_W-1:0],
                       req_data.bus_address[bcfc_pkg::OFFSET_W-1:0]};
   assign idx_ok    = (idx < bcfc_pkg::PTR_W'(bcfc_pkg::FLASH_BYTES));
   assign in_window = (item_ff.bus_address[15:bcfc_pkg::OFFSET_W] ==
                       bcfc_pkg::WIN_BASE[15:bcfc_pkg::OFFSET_W]);
   assign is_ctrl   = (item_ff.bus_address == bcfc_pkg::CTRL_ADDR);
   assign at555     = (offset == bcfc_pkg::OFS_555);
   assign at2aa     = (offset == bcfc_pkg::OFS_2AA);

   // The sector holding the target, clipped to the end of the flash.
   assign sect_base = idx & ~bcfc_pkg::PTR_W'(bcfc_pkg::SECTOR_BYTES - 1);
   always_comb begin
      sect_end = sect_base + bcfc_pkg::PTR_W'(bcfc_pkg::SECTOR_BYTES);
      if (sect_end > bcfc_pkg::PTR_W'(bcfc_pkg::FLASH_BYTES)) begin
         sect_end = bcfc_pkg::PTR_W'(bcfc_pkg::FLASH_BYTES);
      end
   end

   always_comb begin
      state_in     = state_ff;
      unlock_in    = unlock_ff;
      auto_in      = auto_ff;
      ctrl_in      = ctrl_ff;
      resp_pend_in = resp_pend_ff;
      sweep_ptr_in = sweep_ptr_ff;
      sweep_end_in = sweep_end_ff;
      item_in      = item_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = idx[bcfc_pkg::FLASH_AW-1:0];
      ram_wdata    = ram_rdata & item_ff.write_data;
      advance      = 1'b0;

      // The result register empties when the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bcfc_pkg::S_IDLE: begin
            // Present the read address for the incoming beat right away.
            ram_addr = req_idx[bcfc_pkg::FLASH_AW-1:0];
            if (req_accept) begin
               item_in  = req_data;
               state_in = bcfc_pkg::S_EXEC;
            end
         end
         bcfc_pkg::S_EXEC: begin
            state_in = bcfc_pkg::S_DONE;
            rd_in    = 8'h00;
            if (item_ff.command == bcfc_pkg::ACC_READ) begin
               if (is_ctrl) begin
                  rd_in = {item_ff.eeprom_data_out, ctrl_ff[6:0]};
               end else if (in_window) begin
                  if (auto_ff) begin
                     if (offset == bcfc_pkg::OFFSET_W'(0)) begin
                        rd_in = bcfc_pkg::ID_MAKER;
                     end else if (offset == bcfc_pkg::OFFSET_W'(1)) begin
                        rd_in = bcfc_pkg::ID_DEVICE;
                     end else begin
                        rd_in = bcfc_pkg::ERASED;
                     end
                  end else if (idx_ok) begin
                     rd_in = ram_rdata;
                  end else begin
                     rd_in = bcfc_pkg::ERASED;
                  end
               end else begin
                  rd_in = bcfc_pkg::ERASED;
               end
            end else if (is_ctrl) begin
               ctrl_in = item_ff.write_data;
            end else if (in_window && ctrl_ff[7] && ctrl_ff[6]) begin
               // Flash command sequence. A beat that does not advance the
               // sequence falls back to idle and read-array mode.
               if (item_ff.write_data == bcfc_pkg::CMD_RESET) begin
                  advance = 1'b1;
                  auto_in = 1'b0;
                  unlock_in = bcfc_pkg::U_IDLE;
               end else begin
                  case (unlock_ff)
                     bcfc_pkg::U_IDLE: begin
                        if (at555 && item_ff.write_data == bcfc_pkg::CMD_UNLOCK1) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_UNLOCK1;
                        end
                     end
                     bcfc_pkg::U_UNLOCK1: begin
                        if (at2aa && item_ff.write_data == bcfc_pkg::CMD_UNLOCK2) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_UNLOCK2;
                        end
                     end
                     bcfc_pkg::U_UNLOCK2: begin
                        if (at555 && item_ff.write_data == bcfc_pkg::CMD_PROGRAM) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_PROGRAM;
                        end else if (at555 && item_ff.write_data == bcfc_pkg::CMD_ERASE) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_ESETUP;
                        end else if (at555 && item_ff.write_data == bcfc_pkg::CMD_AUTOSEL) begin
                           advance   = 1'b1;
                           auto_in   = 1'b1;
                           unlock_in = bcfc_pkg::U_IDLE;
                        end
                     end
                     bcfc_pkg::U_PROGRAM: begin
                        // Programming can only clear bits: the new byte is old AND data.
                        ram_we = idx_ok;
                     end
                     bcfc_pkg::U_ESETUP: begin
                        if (at555 && item_ff.write_data == bcfc_pkg::CMD_UNLOCK1) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_EUNLK1;
                        end
                     end
                     bcfc_pkg::U_EUNLK1: begin
                        if (at2aa && item_ff.write_data == bcfc_pkg::CMD_UNLOCK2) begin
                           advance   = 1'b1;
                           unlock_in = bcfc_pkg::U_EUNLK2;
                        end
                     end
                     bcfc_pkg::U_EUNLK2: begin
                        if (at555 && item_ff.write_data == bcfc_pkg::CMD_CHIP_ERS) begin
                           sweep_ptr_in = '0;
                           sweep_end_in = bcfc_pkg::PTR_W'(bcfc_pkg::FLASH_BYTES);
                           resp_pend_in = 1'b1;
                           state_in     = bcfc_pkg::S_SWEEP;
                        end else if (item_ff.write_data == bcfc_pkg::CMD_SECT_ERS && idx_ok) begin
                           sweep_ptr_in = sect_base;
                           sweep_end_in = sect_end;
                           resp_pend_in = 1'b1;
                           state_in     = bcfc_pkg::S_SWEEP;
                        end
                     end
                     default: begin
                        advance = 1'b0;
                     end
                  endcase
               end
               if (!advance) begin
                  auto_in   = 1'b0;
                  unlock_in = bcfc_pkg::U_IDLE;
               end
            end
         end
         bcfc_pkg::S_SWEEP: begin
            ram_we       = 1'b1;
            ram_addr     = sweep_ptr_ff[bcfc_pkg::FLASH_AW-1:0];
            ram_wdata    = bcfc_pkg::ERASED;
            sweep_ptr_in = sweep_ptr_ff + bcfc_pkg::PTR_W'(1);
            if (sweep_ptr_in == sweep_end_ff) begin
               state_in     = resp_pend_ff ? bcfc_pkg::S_DONE : bcfc_pkg::S_IDLE;
               resp_pend_in = 1'b0;
            end
         end
         bcfc_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.read_data      = rd_ff;
               rsp_data_in.rom_bank       = ctrl_ff[bcfc_pkg::BANK_W-1:0];
               rsp_data_in.exrom_high     = ctrl_ff[6];
               rsp_data_in.eeprom_select  = ctrl_ff[6];
               rsp_data_in.eeprom_clock   = ctrl_ff[5];
               rsp_data_in.eeprom_data_in = ctrl_ff[4];
               state_in                   = bcfc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bcfc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts the clearing pass over the whole flash.
         state_ff     <= bcfc_pkg::S_SWEEP;
         unlock_ff    <= bcfc_pkg::U_IDLE;
         auto_ff      <= 1'b0;
         ctrl_ff      <= 8'h00;
         resp_pend_ff <= 1'b0;
         sweep_ptr_ff <= '0;
         sweep_end_ff <= bcfc_pkg::PTR_W'(bcfc_pkg::FLASH_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         unlock_ff    <= unlock_in;
         auto_ff      <= auto_in;
         ctrl_ff      <= ctrl_in;
         resp_pend_ff <= resp_pend_in;
         sweep_ptr_ff <= sweep_ptr_in;
         sweep_end_ff <= sweep_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A flash write only happens while a beat is being worked on or swept.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == bcfc_pkg::S_EXEC || state_ff == bcfc_pkg::S_SWEEP))
      else $error("flash RAM written outside execute or sweep");

   // The sweep pointer stays inside its range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcfc_pkg::S_SWEEP) |-> (sweep_ptr_ff < sweep_end_ff))
      else $error("sweep pointer past its end");

   // An accepted beat is executed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == bcfc_pkg::S_EXEC))
      else $error("accepted beat not executed");

   // A finished beat with a free result slot shows up on the result channel.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcfc_pkg::S_DONE && slot_free) |=> rsp_valid_ff)
      else $error("result not delivered");

   // Only one unlock state at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot(unlock_ff))
      else $error("unlock state not one-hot");
`endif

endmodule
`default_nettype wire

// ----- test/banked_cartridge_flash_controller_test.sv -----
// Self-checking testbench for the banked cartridge flash controller.
`timescale 1ns / 1ps
module banked_cartridge_flash_controller_test;
   import bcfc_pkg::*;

   // The run aims at this many request beats. The last TAIL_BEATS of them go
   // through with no idling on either side.
   localparam int ITEM_GOAL     = 550;
   localparam int TAIL_BEATS    = 100;
   // The long receiver hold-off, in cycles. It is long enough for the block to
   // fill up and push back on the request side.
   localparam int LONG_HOLD     = 400;
   // Quiet cycles after the last result, so that a stray extra beat is seen.
   localparam int SETTLE_CYCLES = 16;
   // Sector erases walk 64 KiB each, so the random part may run only a few.
   localparam int SECTOR_BUDGET = 2;

   // Control bits 7 and 6 together arm the flash command decoder.
   localparam logic [7:0] FLASH_ARM = 8'hC0;
   // Reads that hit nothing mapped return an open bus.
   localparam logic [7:0] OPEN_BUS  = 8'hFF;

   // The scoreboard keeps its own copy of the controller's state: the control
   // byte, the bank select, the unlock sequence position, autoselect mode and
   // the whole flash array. Every accepted request beat is run through it, and
   // the result beat it predicts is queued until the block delivers one.
   class flash_mirror;
      bit [7:0]         flash_mem [FLASH_BYTES];
      logic [7:0]       ctrl_reg;
      logic [5:0]       bank_sel;
      unlock_state_type cmd_state;
      logic             id_mode;
      rsp_type          owed_results [$];
      int               mismatches;
      int               compared;
      int               programs;
      int               sector_erases;
      int               chip_erases;
      int               id_reads;

      function new();
         erase_span(0, FLASH_BYTES);
         ctrl_reg  = '0;
         bank_sel  = '0;
         cmd_state = U_IDLE;
         id_mode   = 1'b0;
      endfunction

      function bit flash_armed();
         return ctrl_reg[7] && ctrl_reg[6];
      endfunction

      function int owed();
         return owed_results.size();
      endfunction

      function void erase_span(int unsigned first, int unsigned last);
         for (int unsigned i = first; i < last; i++) flash_mem[i] = ERASED;
      endfunction

      // A window read shows the selected bank, or the two ID bytes while the
      // chip sits in autoselect mode.
      function logic [7:0] window_byte(logic [OFFSET_W-1:0] ofs);
         int unsigned idx;
         if (id_mode) begin
            id_reads++;
            if (ofs == 0) return ID_MAKER;
            if (ofs == 1) return ID_DEVICE;
            return ERASED;
         end
         idx = bank_sel * BANK_BYTES + ofs;
         if (idx >= FLASH_BYTES) return ERASED;
         return flash_mem[idx];
      endfunction

      // One armed write into the window. Anything that does not move the
      // unlock sequence forward drops back to idle and array reads.
      function void run_command(logic [OFFSET_W-1:0] ofs, logic [7:0] data);
         logic        at555;
         logic        at2aa;
         logic        advanced;
         int unsigned idx;
         int unsigned base;
         at555    = ofs == OFS_555;
         at2aa    = ofs == OFS_2AA;
         advanced = 1'b0;
         idx      = bank_sel * BANK_BYTES + ofs;
         if (data == CMD_RESET) begin
            id_mode   = 1'b0;
            cmd_state = U_IDLE;
            return;
         end
         case (cmd_state)
            U_IDLE: begin
               if (at555 && data == CMD_UNLOCK1) begin
                  cmd_state = U_UNLOCK1;
                  advanced  = 1'b1;
               end
            end
            U_UNLOCK1: begin
               if (at2aa && data == CMD_UNLOCK2) begin
                  cmd_state = U_UNLOCK2;
                  advanced  = 1'b1;
               end
            end
            U_UNLOCK2: begin
               if (at555 && data == CMD_PROGRAM) begin
                  cmd_state = U_PROGRAM;
                  advanced  = 1'b1;
               end else if (at555 && data == CMD_ERASE) begin
                  cmd_state = U_ESETUP;
                  advanced  = 1'b1;
               end else if (at555 && data == CMD_AUTOSEL) begin
                  id_mode   = 1'b1;
                  cmd_state = U_IDLE;
                  advanced  = 1'b1;
               end
            end
            U_PROGRAM: begin
               // Programming can only clear bits.
               programs++;
               if (idx < FLASH_BYTES) flash_mem[idx] = flash_mem[idx] & data;
            end
            U_ESETUP: begin
               if (at555 && data == CMD_UNLOCK1) begin
                  cmd_state = U_EUNLK1;
                  advanced  = 1'b1;
               end
            end
            U_EUNLK1: begin
               if (at2aa && data == CMD_UNLOCK2) begin
                  cmd_state = U_EUNLK2;
                  advanced  = 1'b1;
               end
            end
            U_EUNLK2: begin
               if (at555 && data == CMD_CHIP_ERS) begin
                  chip_erases++;
                  erase_span(0, FLASH_BYTES);
               end else if (data == CMD_SECT_ERS && idx < FLASH_BYTES) begin
                  sector_erases++;
                  base = idx / SECTOR_BYTES * SECTOR_BYTES;
                  erase_span(base, (base + SECTOR_BYTES > FLASH_BYTES) ?
                             FLASH_BYTES : base + SECTOR_BYTES);
               end
            end
            default: ;
         endcase
         if (!advanced) begin
            id_mode   = 1'b0;
            cmd_state = U_IDLE;
         end
      endfunction

      function void note_access(req_type beat);
         rsp_type     want;
         logic [15:0] rel;
         logic        in_win;
         rel    = beat.bus_address - WIN_BASE;
         in_win = rel < BANK_BYTES;
         want   = '0;
         if (beat.command == ACC_READ) begin
            if (beat.bus_address == CTRL_ADDR)
               want.read_data = {beat.eeprom_data_out, ctrl_reg[6:0]};
            else if (in_win)
               want.read_data = window_byte(rel[OFFSET_W-1:0]);
            else
               want.read_data = OPEN_BUS;
         end else if (beat.bus_address == CTRL_ADDR) begin
            ctrl_reg = beat.write_data;
            bank_sel = beat.write_data[5:0];
         end else if (in_win && flash_armed()) begin
            run_command(rel[OFFSET_W-1:0], beat.write_data);
         end
         want.rom_bank       = bank_sel;
         want.exrom_high     = ctrl_reg[6];
         want.eeprom_select  = ctrl_reg[6];
         want.eeprom_clock   = ctrl_reg[5];
         want.eeprom_data_in = ctrl_reg[4];
         owed_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $error("result beat %h arrived with no request outstanding", got);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         compared++;
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("rom_bank", want.rom_bank, got.rom_bank);
         compare_field("exrom_high", want.exrom_high, got.exrom_high);
         compare_field("eeprom_select", want.eeprom_select, got.eeprom_select);
         compare_field("eeprom_clock", want.eeprom_clock, got.eeprom_clock);
         compare_field("eeprom_data_in", want.eeprom_data_in, got.eeprom_data_in);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   flash_mirror board;
   int          beats_sent = 0;
   // Set once the run enters its final stretch; both sides stop idling then.
   bit          tail_phase = 1'b0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit          long_hold_req = 1'b0;

   banked_cartridge_flash_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard ceiling on the run. The slowest correct run spends most of its time in
   // the clearing pass after reset, one chip erase and up to three sector erases;
   // this allows several times that.
   initial begin
      #80_000_000;
      $display("FAILURE");
      $finish;
   end

   // The sender drops valid for a burst of cycles. Valid is written once per
   // falling edge, so it is never lowered and raised again in one time step.
   task automatic sender_rest(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Offers one request beat and holds it until the block takes it. Outside the
   // final stretch a random idle burst may follow.
   task automatic issue_access(input req_type beat);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_access(beat);
      beats_sent++;
      tail_phase = beats_sent >= ITEM_GOAL - TAIL_BEATS;
      if (!tail_phase && $urandom_range(0, 3) == 0) sender_rest($urandom_range(1, 9));
   endtask

   task automatic bus_read(input logic [15:0] addr, input logic dout);
      req_type beat;
      beat.command         = ACC_READ;
      beat.bus_address     = addr;
      beat.write_data      = 8'($urandom);
      beat.eeprom_data_out = dout;
      issue_access(beat);
   endtask

   task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
      req_type beat;
      beat.command         = ACC_WRITE;
      beat.bus_address     = addr;
      beat.write_data      = data;
      beat.eeprom_data_out = 1'($urandom);
      issue_access(beat);
   endtask

   task automatic flash_write(input logic [OFFSET_W-1:0] ofs, input logic [7:0] data);
      bus_write(WIN_BASE + 16'(ofs), data);
   endtask

   task automatic unlock_pair();
      flash_write(OFS_555, CMD_UNLOCK1);
      flash_write(OFS_2AA, CMD_UNLOCK2);
   endtask

   task automatic program_byte_seq(input logic [OFFSET_W-1:0] ofs, input logic [7:0] data);
      unlock_pair();
      flash_write(OFS_555, CMD_PROGRAM);
      flash_write(ofs, data);
   endtask

   task automatic id_mode_seq();
      unlock_pair();
      flash_write(OFS_555, CMD_AUTOSEL);
   endtask

   // The six-write erase sequence; the last write decides between chip erase,
   // sector erase and a plain abort.
   task automatic erase_seq(input logic [OFFSET_W-1:0] ofs, input logic [7:0] data);
      unlock_pair();
      flash_write(OFS_555, CMD_ERASE);
      unlock_pair();
      flash_write(ofs, data);
   endtask

   // A byte that never moves the unlock sequence on from any state.
   function automatic logic [7:0] stray_byte();
      logic [7:0] data;
      do data = 8'($urandom);
      while (data inside {CMD_UNLOCK1, CMD_UNLOCK2, CMD_PROGRAM, CMD_ERASE,
                          CMD_AUTOSEL, CMD_RESET, CMD_CHIP_ERS, CMD_SECT_ERS});
      return data;
   endfunction

   // Most offsets land on a few hot bytes, so programs and reads meet again.
   function automatic logic [OFFSET_W-1:0] pick_offset();
      if ($urandom_range(0, 9) < 6) return OFFSET_W'($urandom_range(0, 15));
      return OFFSET_W'($urandom);
   endfunction

   // Control bytes mostly keep the decoder armed and stay within a few banks.
   function automatic logic [7:0] pick_control();
      logic [7:0] data;
      data = 8'($urandom);
      if ($urandom_range(0, 9) != 0) data[7:6] = 2'b11;
      if ($urandom_range(0, 9) < 7) data[5:0] = 6'($urandom_range(0, 3));
      return data;
   endfunction

   // An unlock sequence cut off part way, either by a reset command or by a
   // write that fits no step.
   task automatic broken_seq();
      int steps;
      steps = $urandom_range(1, 5);
      for (int s = 0; s < steps; s++) begin
         case (s)
            0, 3: flash_write(OFS_555, CMD_UNLOCK1);
            1, 4: flash_write(OFS_2AA, CMD_UNLOCK2);
            default: flash_write(OFS_555, CMD_ERASE);
         endcase
      end
      if ($urandom_range(0, 3) == 0) flash_write(pick_offset(), CMD_RESET);
      else flash_write(pick_offset(), stray_byte());
   endtask

   // A fully random beat: any kind, any address, any data.
   task automatic stray_beat();
      req_type beat;
      beat.command         = 1'($urandom);
      beat.write_data      = 8'($urandom);
      beat.eeprom_data_out = 1'($urandom);
      case ($urandom_range(0, 3))
         0: beat.bus_address = WIN_BASE + 16'(pick_offset());
         1: beat.bus_address = CTRL_ADDR;
         default: beat.bus_address = 16'($urandom);
      endcase
      issue_access(beat);
   endtask

   // Lowers valid and waits until every owed result beat has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.owed() != 0) @(posedge clock);
   endtask

   // The receiver stalls in random bursts, runs free in between, serves one
   // long hold-off on request and stops stalling in the final stretch. Each
   // falling edge carries exactly one write of the stall line.
   initial begin
      int   span;
      logic level;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            span  = LONG_HOLD;
            level = 1'b1;
         end else if (!tail_phase && $urandom_range(0, 2) == 0) begin
            span  = $urandom_range(1, 9);
            level = 1'b1;
         end else begin
            span  = $urandom_range(1, 12);
            level = 1'b0;
         end
         repeat (span) begin
            @(negedge clock);
            rsp_stall <= level;
         end
      end
   end

   // Result beats are sampled on the rising edge, where valid and stall are
   // both settled from the falling edge before.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_result(rsp_data);
   end

   initial begin
      int roll;
      int sector_budget;
      bit hold_sent;
      bit pause_done;
      bit wipe_done;
      board         = new();
      sector_budget = SECTOR_BUDGET;
      hold_sent     = 1'b0;
      pause_done    = 1'b0;
      wipe_done     = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats. The block is still clearing its flash after reset, so
      // the first beat waits out that pass on the request stall.
      // Address and data extremes outside every mapped range.
      bus_read(16'hFFFF, 1'b1);
      bus_write(16'h0000, 8'hFF);
      // The decoder is not armed yet, so this window write is dropped.
      flash_write(OFS_555, CMD_UNLOCK1);
      // The control register reads back with the EEPROM data-out pin in bit 7.
      bus_read(CTRL_ADDR, 1'b1);
      // Arm the decoder on bank 5 and program the last byte of the window.
      bus_write(CTRL_ADDR, FLASH_ARM | 8'h05);
      program_byte_seq(13'h1FFF, 8'h5A);
      bus_read(WIN_BASE + 16'h1FFF, 1'b0);
      // Autoselect shows the maker and device IDs, and open bus elsewhere.
      id_mode_seq();
      bus_read(WIN_BASE, 1'b0);
      bus_read(WIN_BASE + 16'h0001, 1'b1);
      bus_read(WIN_BASE + 16'h0002, 1'b0);
      // The reset command leaves autoselect from anywhere.
      flash_write(13'h0123, CMD_RESET);
      // A write that fits no step aborts a started sequence.
      flash_write(OFS_555, CMD_UNLOCK1);
      flash_write(13'h0123, 8'h00);
      // Sector erase wipes the 64 KiB sector holding bank 5, programmed byte
      // included.
      erase_seq(13'h0000, CMD_SECT_ERS);
      bus_read(WIN_BASE + 16'h1FFF, 1'b1);

      // Random part. Most of it is well-formed command sequences with random
      // targets and data; the rest is register traffic, reads, cut-off
      // sequences and random noise.
      while (beats_sent < ITEM_GOAL) begin
         if (!hold_sent && beats_sent >= 180) begin
            // The receiver holds off for a long stretch while beats keep coming.
            hold_sent     = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!pause_done && beats_sent >= 330) begin
            // The sender goes quiet until every owed result has come back.
            pause_done = 1'b1;
            wait_for_results();
         end
         if (!wipe_done && beats_sent >= 420) begin
            // One chip erase, once plenty of bytes have been programmed, so
            // that later reads show it took effect.
            wipe_done = 1'b1;
            bus_write(CTRL_ADDR, FLASH_ARM | 8'($urandom_range(0, 3)));
            erase_seq(OFS_555, CMD_CHIP_ERS);
         end
         roll = $urandom_range(0, 99);
         // Window traffic is wasted while the decoder is disarmed, so it is
         // usually armed again first.
         if (roll >= 30 && roll < 93 && !board.flash_armed() && $urandom_range(0, 9) != 0)
            bus_write(CTRL_ADDR, pick_control() | FLASH_ARM);
         if (roll < 15) begin
            bus_write(CTRL_ADDR, pick_control());
         end else if (roll < 30) begin
            bus_read(CTRL_ADDR, 1'($urandom));
         end else if (roll < 52) begin
            bus_read(WIN_BASE + 16'(pick_offset()), 1'($urandom));
         end else if (roll < 72) begin
            program_byte_seq(pick_offset(), 8'($urandom));
         end else if (roll < 80) begin
            id_mode_seq();
            repeat ($urandom_range(1, 3))
               bus_read(WIN_BASE + 16'($urandom_range(0, 3)), 1'($urandom));
            if ($urandom_range(0, 1) == 0) flash_write(pick_offset(), CMD_RESET);
         end else if (roll < 87) begin
            broken_seq();
         end else if (roll < 91) begin
            // Erase sequences beyond the budget end in a harmless abort.
            if (sector_budget > 0) begin
               sector_budget--;
               erase_seq(pick_offset(), CMD_SECT_ERS);
            end else begin
               erase_seq(pick_offset(), stray_byte());
            end
         end else begin
            stray_beat();
         end
      end

      // Drain, then leave a few quiet cycles for any beat that should not come.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d bus beats: %0d byte programs, %0d sector erases, %0d chip erases.",
               beats_sent, board.programs, board.sector_erases, board.chip_erases);
      $display("Compared %0d result beats, %0d of them autoselect reads; %0d mismatches.",
               board.compared, board.id_reads, board.mismatches);
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
